// ===== hw/rtl/pcac_pkg.sv =====
package pcac_pkg;

    localparam int OP_W     = 2;
    localparam int CAPT_W   = 16;
    localparam int FREQ_W   = 27;
    localparam int PERIOD_W = 16;
    localparam int CURR_W   = 24;
    localparam int RATE_W   = 16;
    localparam int STOP_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;
    localparam int ROLL_W   = 2;

    localparam int DIV_NUM_W = FREQ_W;
    localparam int DIV_DEN_W = PERIOD_W;

    localparam logic [OP_W-1:0] OP_CAPTURE  = 2'd0;
    localparam logic [OP_W-1:0] OP_ROLLOVER = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_FREQ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECREASE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TICKS   = 2'd3;

    localparam logic [FREQ_W-1:0] TIMER_FREQ_RESET = 27'd10000;
    localparam logic [CURR_W-1:0] NUMERATOR_RESET  = 24'd7500000;
    localparam logic [RATE_W-1:0] DECREASE_RESET   = 16'd2000;
    localparam logic [STOP_W-1:0] STOP_TICKS_RESET = 8'd10;

    localparam logic [STOP_W-1:0] STALE_MAX    = 8'd255;
    localparam logic [ROLL_W-1:0] ROLLOVER_MAX = 2'd3;
    localparam logic [ROLL_W-1:0] ROLLOVER_ONE = 2'd1;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CAPT_W-1:0] capture_value;
    } in_item_t;

    typedef struct packed {
        logic [FREQ_W-1:0]   frequency_hz;
        logic [PERIOD_W-1:0] period_ticks;
        logic [CURR_W-1:0]   current_ma;
        logic                current_send;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_write;
        logic clear_current;
        logic second;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic two_results;
        logic div_done;
    } dp_stat_t;

endpackage

// ===== hw/rtl/pcac_div.sv =====
module pcac_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pcac_pkg::DIV_NUM_W-1:0]  dividend,
    input  logic [pcac_pkg::DIV_DEN_W-1:0]  divisor,
    output logic                            done,
    output logic [pcac_pkg::DIV_NUM_W-1:0]  quotient
);
    import pcac_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIV_DEN_W:0] rem_shift;
    logic [DIV_DEN_W:0] diff;
    logic               ge;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_NUM_W-1]};
        diff      = rem_shift - {1'b0, den_reg};
        ge        = rem_shift >= {1'b0, den_reg};

        rem_next   = rem_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;

        if (start)
        begin
            rem_next   = '0;
            quo_next   = dividend;
            den_next   = (divisor == '0) ? DIV_DEN_W'(1) : divisor;
            count_next = CNT_W'(DIV_NUM_W - 1);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIV_DEN_W-1:0] : rem_shift[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], ge};
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/pcac_dp.sv =====
module pcac_dp
#(
    parameter int TIMER_WIDTH = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  pcac_pkg::ctrl_cmd_t               cmd,
    output pcac_pkg::dp_stat_t                stat,
    input  pcac_pkg::in_item_t                in_item,
    output pcac_pkg::out_item_t               out_item,
    input  logic                              cfg_write,
    input  logic [pcac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcac_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pcac_pkg::*;

    localparam int CAP_W = (TIMER_WIDTH < PERIOD_W) ? TIMER_WIDTH : PERIOD_W;
    localparam logic [PERIOD_W-1:0] CAP_MASK =
        PERIOD_W'((17'd1 << CAP_W) - 17'd1);

    logic [FREQ_W-1:0]   timer_freq_reg;
    logic [CURR_W-1:0]   numerator_reg;
    logic [RATE_W-1:0]   decrease_reg;
    logic [STOP_W-1:0]   stop_ticks_reg;

    logic [PERIOD_W-1:0] last_capture_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [FREQ_W-1:0]   freq_reg;
    logic                fresh_reg;
    logic [ROLL_W-1:0]   rollover_reg;
    logic [STOP_W-1:0]   stale_reg;
    logic [CURR_W-1:0]   current_reg;
    logic                send_reg;
    logic                two_reg;
    logic                div_capture_reg;

    logic [PERIOD_W-1:0] cur;
    logic [PERIOD_W-1:0] period_new;
    logic [ROLL_W-1:0]   rollover_inc;
    logic [STOP_W-1:0]   stale_inc;
    logic                ramp;
    logic                above;
    logic [CURR_W-1:0]   current_dec;
    logic                two_new;

    logic                    div_done;
    logic [DIV_NUM_W-1:0]    quotient;
    logic [DIV_NUM_W-1:0]    dividend;
    logic [DIV_DEN_W-1:0]    divisor;

    always_comb
    begin
        cur        = in_item.capture_value & CAP_MASK;
        period_new = (cur > last_capture_reg) ? (cur - last_capture_reg)
                                              : (CAP_MASK + cur - last_capture_reg);
        rollover_inc = (rollover_reg < ROLLOVER_MAX) ? rollover_reg + ROLL_W'(1)
                                                     : rollover_reg;
        stale_inc    = (stale_reg < STALE_MAX) ? stale_reg + STOP_W'(1) : stale_reg;
        ramp         = stale_inc > stop_ticks_reg;
        above        = current_reg > CURR_W'(decrease_reg);
        current_dec  = above ? current_reg - CURR_W'(decrease_reg) : '0;
        two_new      = above && (current_dec <= CURR_W'(decrease_reg));
    end

    assign dividend = div_capture_reg ? timer_freq_reg : DIV_NUM_W'(numerator_reg);
    assign divisor  = period_reg;

    pcac_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign stat.need_div    = (in_item.operation == OP_CAPTURE)
                           || ((in_item.operation == OP_TICK) && fresh_reg);
    assign stat.two_results = two_reg;
    assign stat.div_done    = div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_freq_reg <= TIMER_FREQ_RESET;
            numerator_reg  <= NUMERATOR_RESET;
            decrease_reg   <= DECREASE_RESET;
            stop_ticks_reg <= STOP_TICKS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TIMER_FREQ: timer_freq_reg <= cfg_data[FREQ_W-1:0];
                CFG_NUMERATOR:  numerator_reg  <= cfg_data[CURR_W-1:0];
                CFG_DECREASE:   decrease_reg   <= cfg_data[RATE_W-1:0];
                CFG_STOP_TICKS: stop_ticks_reg <= cfg_data[STOP_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_capture_reg <= '0;
            period_reg       <= '0;
            freq_reg         <= '0;
            fresh_reg        <= 1'b0;
            rollover_reg     <= '0;
            stale_reg        <= '0;
            current_reg      <= '0;
            send_reg         <= 1'b0;
            two_reg          <= 1'b0;
            div_capture_reg  <= 1'b0;
        end
        else if (cmd.accept)
        begin
            send_reg <= 1'b0;
            two_reg  <= 1'b0;
            unique case (in_item.operation)
                OP_CAPTURE:
                begin
                    period_reg       <= period_new;
                    last_capture_reg <= cur;
                    fresh_reg        <= 1'b1;
                    rollover_reg     <= '0;
                    div_capture_reg  <= 1'b1;
                end
                OP_ROLLOVER:
                begin
                    rollover_reg <= rollover_inc;
                    if (rollover_inc > ROLLOVER_ONE)
                    begin
                        freq_reg <= '0;
                    end
                end
                OP_TICK:
                begin
                    div_capture_reg <= 1'b0;
                    if (fresh_reg)
                    begin
                        fresh_reg <= 1'b0;
                        stale_reg <= '0;
                        send_reg  <= 1'b1;
                    end
                    else
                    begin
                        stale_reg <= stale_inc;
                        if (ramp)
                        begin
                            send_reg    <= 1'b1;
                            two_reg     <= two_new;
                            current_reg <= current_dec;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.div_write)
        begin
            if (div_capture_reg)
            begin
                freq_reg <= quotient;
            end
            else
            begin
                current_reg <= quotient[CURR_W-1:0];
            end
        end
        else if (cmd.clear_current)
        begin
            current_reg <= '0;
        end
    end

    always_comb
    begin
        out_item.frequency_hz = freq_reg;
        out_item.period_ticks = period_reg;
        out_item.current_ma   = current_reg;
        out_item.current_send = send_reg;
        out_item.last         = cmd.second || !two_reg;
    end

endmodule

// ===== hw/rtl/pcac_ctrl.sv =====
module pcac_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  pcac_pkg::dp_stat_t   stat,
    output pcac_pkg::ctrl_cmd_t  cmd
);
    import pcac_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_EMIT_A = 3'd3;
    localparam logic [2:0] S_EMIT_B = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next        = state_reg;
        cmd.accept        = 1'b0;
        cmd.div_start     = 1'b0;
        cmd.div_write     = 1'b0;
        cmd.clear_current = 1'b0;
        cmd.second        = (state_reg == S_EMIT_B);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.need_div ? S_START : S_EMIT_A;
                end
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.div_write = 1'b1;
                    state_next    = S_EMIT_A;
                end
            end
            S_EMIT_A:
            begin
                if (!out_stall)
                begin
                    if (stat.two_results)
                    begin
                        cmd.clear_current = 1'b1;
                        state_next        = S_EMIT_B;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMIT_B:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_EMIT_A) || (state_reg == S_EMIT_B);

endmodule

// ===== hw/rtl/pedal_cadence_assist_current.sv =====
// Pedal cadence assist current. Each input item is a capture edge, a timer
// rollover or an update tick; each yields one result item, or two when a
// ramp-down step leaves the current at or below the decrease step. Items
// are taken one at a time. A capture edge or a tick with a fresh period runs
// the shared bit-serial divider, one quotient bit per cycle over 27 bits, so
// such an item shows its result only after the divider has finished; any
// other item shows its result in the cycle right after acceptance. A second
// result follows in the cycle after the first is taken. A zero period
// divides as one. Configuration writes are always ready.
module pedal_cadence_assist_current
#(
    parameter int TIMER_WIDTH = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  pcac_pkg::in_item_t                in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output pcac_pkg::out_item_t               out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pcac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcac_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pcac_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    pcac_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    pcac_dp #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_item   (in_item),
        .out_item  (out_item),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

    import pcac_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
    localparam int              CYCLE_LIMIT = 1000000;
    localparam int              PHASES      = 8;
    localparam int              PHASE_ITEMS = 150;
    localparam int              STALE_RUN   = 280;

    typedef struct packed {
        logic                  reg_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        in_item_t              item;
        logic                  known;
        out_item_t             want;
    } step_t;

    localparam out_item_t NONE = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [FREQ_W-1:0]   cf_timer_freq;
    logic [CURR_W-1:0]   cf_numerator;
    logic [RATE_W-1:0]   cf_decrease;
    logic [STOP_W-1:0]   cf_stop;

    logic [CAPT_W-1:0]   last_capt;
    logic [PERIOD_W-1:0] period_q;
    logic [FREQ_W-1:0]   freq_q;
    logic                fresh_q;
    logic [ROLL_W-1:0]   rollovers;
    logic [STOP_W-1:0]   stale_ticks;
    logic [CURR_W-1:0]   assist_ma;

    out_item_t           pending_results [$];
    logic                known_on;
    out_item_t           known_want;
    logic [CAPT_W-1:0]   cap_pos;
    logic                idle_on;
    int                  stall_left;
    int                  errors;

    step_t plan [26] = '{
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_TICK, 16'h1234}, 1'b1,
          '{27'd0, 16'd0, 24'd0, 1'b0, 1'b1}},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_ROLLOVER, 16'h0000}, 1'b1,
          '{27'd0, 16'd0, 24'd0, 1'b0, 1'b1}},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_UNUSED, 16'hFFFF}, 1'b1,
          '{27'd0, 16'd0, 24'd0, 1'b0, 1'b1}},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_CAPTURE, 16'h0000}, 1'b1,
          '{27'd0, 16'd65535, 24'd0, 1'b0, 1'b1}},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_TICK, 16'h0000}, 1'b0, NONE},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_CAPTURE, 16'hFFFF}, 1'b0, NONE},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_CAPTURE, 16'h0000}, 1'b0, NONE},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_TICK, 16'h0000}, 1'b1,
          '{27'd10000, 16'd0, 24'd7500000, 1'b1, 1'b1}},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_CAPTURE, 16'h0064}, 1'b0, NONE},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_ROLLOVER, 16'h0000}, 1'b0, NONE},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_ROLLOVER, 16'h0000}, 1'b0, NONE},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_ROLLOVER, 16'h0000}, 1'b0, NONE},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_ROLLOVER, 16'h0000}, 1'b0, NONE},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_TICK, 16'h0000}, 1'b0, NONE},
        '{1'b1, CFG_STOP_TICKS, 27'd0, '{OP_TICK, 16'h0000}, 1'b0, NONE},
        '{1'b1, CFG_DECREASE, 27'd40000, '{OP_TICK, 16'h0000}, 1'b0, NONE},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_TICK, 16'h0000}, 1'b0, NONE},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_TICK, 16'h0000}, 1'b0, NONE},
        '{1'b1, CFG_TIMER_FREQ, 27'd100000000, '{OP_TICK, 16'h0000}, 1'b0, NONE},
        '{1'b1, CFG_NUMERATOR, 27'd16777215, '{OP_TICK, 16'h0000}, 1'b0, NONE},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_CAPTURE, 16'h0001}, 1'b0, NONE},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_CAPTURE, 16'h0002}, 1'b0, NONE},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_TICK, 16'h0000}, 1'b0, NONE},
        '{1'b1, CFG_DECREASE, 27'd0, '{OP_TICK, 16'h0000}, 1'b0, NONE},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_TICK, 16'h0000}, 1'b0, NONE},
        '{1'b0, CFG_TIMER_FREQ, 27'd0, '{OP_CAPTURE, 16'hFFFF}, 1'b0, NONE}
    };

    pedal_cadence_assist_current dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic void queue_result(input logic send, input logic fin);
        out_item_t r;
        r.frequency_hz = freq_q;
        r.period_ticks = period_q;
        r.current_ma   = assist_ma;
        r.current_send = send;
        r.last         = fin;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_assist(input in_item_t it);
        logic [CAPT_W:0] span;
        case (it.operation)
            OP_CAPTURE:
            begin
                if (it.capture_value > last_capt)
                begin
                    period_q = it.capture_value - last_capt;
                end
                else
                begin
                    span     = 17'h0FFFF + it.capture_value - last_capt;
                    period_q = span[PERIOD_W-1:0];
                end
                freq_q    = (period_q == '0) ? cf_timer_freq : cf_timer_freq / period_q;
                fresh_q   = 1'b1;
                last_capt = it.capture_value;
                rollovers = '0;
                queue_result(1'b0, 1'b1);
            end
            OP_ROLLOVER:
            begin
                if (rollovers < ROLLOVER_MAX)
                    rollovers = rollovers + 1'b1;
                if (rollovers > ROLLOVER_ONE)
                    freq_q = '0;
                queue_result(1'b0, 1'b1);
            end
            OP_TICK:
            begin
                if (fresh_q)
                begin
                    fresh_q     = 1'b0;
                    stale_ticks = '0;
                    assist_ma   = (period_q == '0) ? cf_numerator : cf_numerator / period_q;
                    queue_result(1'b1, 1'b1);
                end
                else
                begin
                    if (stale_ticks < STALE_MAX)
                        stale_ticks = stale_ticks + 1'b1;
                    if (stale_ticks > cf_stop)
                    begin
                        if (assist_ma > cf_decrease)
                        begin
                            assist_ma = assist_ma - cf_decrease;
                            queue_result(1'b1, assist_ma > cf_decrease);
                        end
                        if (assist_ma <= cf_decrease)
                        begin
                            assist_ma = '0;
                            queue_result(1'b1, 1'b1);
                        end
                    end
                    else
                    begin
                        queue_result(1'b0, 1'b1);
                    end
                end
            end
            default:
            begin
                queue_result(1'b0, 1'b1);
            end
        endcase
    endfunction

    always @(posedge clk)
    begin : watch
        out_item_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TIMER_FREQ: cf_timer_freq = cfg_data[FREQ_W-1:0];
                    CFG_NUMERATOR:  cf_numerator  = cfg_data[CURR_W-1:0];
                    CFG_DECREASE:   cf_decrease   = cfg_data[RATE_W-1:0];
                    CFG_STOP_TICKS: cf_stop       = cfg_data[STOP_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                predict_assist(in_item);
                if (known_on)
                begin
                    void'(pending_results.pop_back());
                    pending_results.push_back(known_want);
                end
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result item %p", out_item);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_item.frequency_hz !== want.frequency_hz)
                    begin
                        $error("frequency_hz: expected %0d, got %0d",
                               want.frequency_hz, out_item.frequency_hz);
                        errors++;
                    end
                    if (out_item.period_ticks !== want.period_ticks)
                    begin
                        $error("period_ticks: expected %0d, got %0d",
                               want.period_ticks, out_item.period_ticks);
                        errors++;
                    end
                    if (out_item.current_ma !== want.current_ma)
                    begin
                        $error("current_ma: expected %0d, got %0d",
                               want.current_ma, out_item.current_ma);
                        errors++;
                    end
                    if (out_item.current_send !== want.current_send)
                    begin
                        $error("current_send: expected %0d, got %0d",
                               want.current_send, out_item.current_send);
                        errors++;
                    end
                    if (out_item.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, out_item.last);
                        errors++;
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 11);
        if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall = 1'b0;
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[pedal_cadence_assist_current] ERROR");
        $finish;
    end

    task automatic offer_item(input logic [OP_W-1:0] op, input logic [CAPT_W-1:0] value);
        if (idle_on && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 11)) @(negedge clk);
        in_item.operation     = op;
        in_item.capture_value = value;
        in_valid              = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_quiet();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_traffic(input int quota);
        int                sent;
        int                n;
        logic [CAPT_W-1:0] delta;
        logic [OP_W-1:0]   op;
        sent = 0;
        while (sent < quota)
        begin
            n = $urandom_range(0, 99);
            if (n < 60)
            begin
                case ($urandom_range(0, 5))
                    0:       delta = CAPT_W'($urandom);
                    1:       delta = CAPT_W'($urandom_range(0, 3));
                    default: delta = CAPT_W'($urandom_range(20, 4000));
                endcase
                cap_pos = cap_pos + delta;
                if ($urandom_range(0, 3) == 0)
                begin
                    offer_item(OP_ROLLOVER, CAPT_W'($urandom));
                    sent++;
                end
                offer_item(OP_CAPTURE, cap_pos);
                sent++;
                repeat ($urandom_range(1, 2))
                begin
                    offer_item(OP_TICK, CAPT_W'($urandom));
                    sent++;
                end
            end
            else if (n < 80)
            begin
                repeat ($urandom_range(1, 25))
                begin
                    offer_item(OP_TICK, CAPT_W'($urandom));
                    sent++;
                end
            end
            else if (n < 90)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    offer_item(OP_ROLLOVER, CAPT_W'($urandom));
                    sent++;
                end
            end
            else
            begin
                op    = OP_W'($urandom_range(0, 3));
                delta = CAPT_W'($urandom);
                if (op == OP_CAPTURE)
                    cap_pos = delta;
                offer_item(op, delta);
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [FREQ_W-1:0] tf;
        logic [CURR_W-1:0] num;
        logic [RATE_W-1:0] dec;
        logic [STOP_W-1:0] stp;

        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_item       = '0;
        out_stall     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_TIMER_FREQ;
        cfg_data      = '0;
        cf_timer_freq = TIMER_FREQ_RESET;
        cf_numerator  = NUMERATOR_RESET;
        cf_decrease   = DECREASE_RESET;
        cf_stop       = STOP_TICKS_RESET;
        last_capt     = '0;
        period_q      = '0;
        freq_q        = '0;
        fresh_q       = 1'b0;
        rollovers     = '0;
        stale_ticks   = '0;
        assist_ma     = '0;
        known_on      = 1'b0;
        known_want    = NONE;
        cap_pos       = 16'hFFFF;
        idle_on       = 1'b1;
        stall_left    = 0;
        errors        = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].reg_write)
            begin
                wait_quiet();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                known_on   = plan[i].known;
                known_want = plan[i].want;
                offer_item(plan[i].item.operation, plan[i].item.capture_value);
                known_on   = 1'b0;
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            tf  = FREQ_W'($urandom_range(1, 100000000));
            num = CURR_W'($urandom_range(1, 24'hFFFFFF));
            dec = ($urandom_range(0, 3) == 0) ? RATE_W'($urandom_range(0, 65535))
                                              : RATE_W'($urandom_range(0, 3000));
            stp = STOP_W'($urandom_range(0, 12));
            case (ph)
                0:
                begin
                    tf  = TIMER_FREQ_RESET;
                    num = NUMERATOR_RESET;
                    dec = DECREASE_RESET;
                    stp = STOP_TICKS_RESET;
                end
                1:
                begin
                    tf  = 27'd1;
                    num = 24'd1;
                    dec = 16'd0;
                    stp = 8'd0;
                end
                2:
                begin
                    tf  = 27'd100000000;
                    num = 24'hFFFFFF;
                    dec = 16'hFFFF;
                    stp = 8'd0;
                end
                3: stp = STALE_MAX;
                4: stp = STALE_MAX - 1'b1;
                default: ;
            endcase
            idle_on = (ph == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            wait_quiet();
            write_reg(CFG_TIMER_FREQ, tf);
            write_reg(CFG_NUMERATOR, CFG_DATA_W'(num));
            write_reg(CFG_DECREASE, CFG_DATA_W'(dec));
            write_reg(CFG_STOP_TICKS, CFG_DATA_W'(stp));
            random_traffic(PHASE_ITEMS);
            if (ph == 3 || ph == 4)
            begin
                cap_pos = cap_pos + 16'd150;
                offer_item(OP_CAPTURE, cap_pos);
                offer_item(OP_TICK, CAPT_W'($urandom));
                repeat (STALE_RUN) offer_item(OP_TICK, CAPT_W'($urandom));
            end
        end

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("[pedal_cadence_assist_current] OK");
        else
            $display("[pedal_cadence_assist_current] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pcac_pkg.sv
hw/rtl/pcac_div.sv
hw/rtl/pcac_dp.sv
hw/rtl/pcac_ctrl.sv
hw/rtl/pedal_cadence_assist_current.sv
tb/tb_top.sv
